FILE: sv/shifting_array_list_defines.svh
// assertion macros for the shifting array list checker
// no dependencies; included by the checker file only
`ifndef SHIFTING_ARRAY_LIST_DEFINES_SVH
`define SHIFTING_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define ALR_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shifting_array_list check failed");

// next-cycle implication, clocked on aclk, off during reset
`define ALR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shifting_array_list check failed");

`endif

FILE: sv/alr_pkg.sv
// shared constants, request codes and control types for the shifting array list
// no dependencies
package alr_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int REQ_W    = 4;
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;
    localparam int GRP_SZ   = 8;
    localparam int NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd4;
    localparam logic [REQ_W-1:0] REQ_ERASE      = 4'd5;
    localparam logic [REQ_W-1:0] REQ_READ_AT    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ_FRONT = 4'd7;
    localparam logic [REQ_W-1:0] REQ_READ_BACK  = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_INS  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        at;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_t;

endpackage

FILE: sv/alr_cell.sv
// one storage cell of the list: holds one word, shifts with its neighbors
// depends on alr_pkg
module alr_cell
    import alr_pkg::*;
(
    input  logic                    aclk,
    input  logic [IDX_W-1:0]        idx,
    input  cmd_t                    cmd,
    input  rd_t                     rd,
    input  logic signed [VAL_W-1:0] left_data,
    input  logic signed [VAL_W-1:0] right_data,
    output logic signed [VAL_W-1:0] data,
    output logic signed [VAL_W-1:0] tap
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic signed [VAL_W-1:0] tap_reg;
    logic signed [VAL_W-1:0] tap_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.mode)
            MODE_INS: begin
                if (idx == cmd.at) begin
                    data_next = cmd.value;
                end else if (idx > cmd.at) begin
                    data_next = left_data;
                end
            end
            MODE_DEL: begin
                if (idx >= cmd.at) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    assign tap_next = (rd.en && (rd.addr == idx)) ? data_reg : '0;

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

FILE: sv/alr_ctrl.sv
// request decode: status, new count, shift command and read address
// depends on alr_pkg
module alr_ctrl
    import alr_pkg::*;
(
    input  logic [REQ_W-1:0]        req_type,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    input  logic [CNT_W-1:0]        used,
    output cmd_t                    cmd,
    output rd_t                     rd,
    output logic [CNT_W-1:0]        used_next,
    output logic [STAT_W-1:0]       status
);

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] used_c;
    logic             full;
    logic             empty;

    assign pos_c  = CMP_W'(position);
    assign used_c = CMP_W'(used);
    assign full   = (used >= CNT_W'(CAPACITY));
    assign empty  = (used == '0);

    always_comb begin
        cmd.mode  = MODE_NONE;
        cmd.at    = '0;
        cmd.value = value;
        rd.en     = 1'b0;
        rd.addr   = '0;
        used_next = used;
        status    = ST_OK;
        case (req_type)
            REQ_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.mode  = MODE_INS;
                    cmd.at    = IDX_W'(used);
                    used_next = used + CNT_W'(1);
                end
            end
            REQ_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.mode  = MODE_INS;
                    used_next = used + CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    used_next = used - CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.mode  = MODE_DEL;
                    used_next = used - CNT_W'(1);
                end
            end
            REQ_INSERT: begin
                if (pos_c > used_c) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.mode  = MODE_INS;
                    cmd.at    = IDX_W'(pos_c);
                    used_next = used + CNT_W'(1);
                end
            end
            REQ_ERASE: begin
                if (pos_c >= used_c) begin
                    status = ST_BADPOS;
                end else begin
                    cmd.mode  = MODE_DEL;
                    cmd.at    = IDX_W'(pos_c);
                    used_next = used - CNT_W'(1);
                end
            end
            REQ_READ_AT: begin
                if (pos_c >= used_c) begin
                    status = ST_BADPOS;
                end else begin
                    rd.en   = 1'b1;
                    rd.addr = IDX_W'(pos_c);
                end
            end
            REQ_READ_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd.en = 1'b1;
                end
            end
            REQ_READ_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    rd.en   = 1'b1;
                    rd.addr = IDX_W'(used - CNT_W'(1));
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

endmodule

FILE: sv/shifting_array_list.sv
// shifting array list top level: request decode, row of cells, registered read tree
// after a request is accepted the read tree fills in S_TAP, S_GRP and S_SUM; the result
// is valid in S_DONE. one request in flight: a new request is taken only in S_IDLE, after
// the result is taken and the three-stage read tree (cell tap, group of 8, final merge) has run
// reset: aresetn synchronous active low clears count and control; cell contents stay undefined
// depends on alr_pkg, alr_ctrl, alr_cell
module shifting_array_list
    import alr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // req_type[3:0], position[9:4], value[41:10]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // read_value[31:0], count[38:32], status[40:39]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TAP  = 3'd1;
    localparam logic [2:0] S_GRP  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        used_reg;
    logic [CNT_W-1:0]        used_dec;
    logic [STAT_W-1:0]       stat_dec;
    logic [STAT_W-1:0]       stat_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [VAL_W-1:0] rdval_reg;
    logic signed [VAL_W-1:0] rdval_next;
    cmd_t                    cmd_dec;
    cmd_t                    cmd_cell;
    rd_t                     rd_dec;
    rd_t                     rd_reg;
    logic                    s_accept;

    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic signed [VAL_W-1:0] cell_tap  [CAPACITY];
    logic signed [VAL_W-1:0] grp_next  [NGRP];
    logic signed [VAL_W-1:0] grp_reg   [NGRP];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {7'b0, stat_reg, COUNT_W'(cnt_reg), rdval_reg};

    alr_ctrl u_ctrl (
        .req_type  (s_tdata[3:0]),
        .position  (s_tdata[9:4]),
        .value     (s_tdata[41:10]),
        .used      (used_reg),
        .cmd       (cmd_dec),
        .rd        (rd_dec),
        .used_next (used_dec),
        .status    (stat_dec)
    );

    always_comb begin
        cmd_cell = cmd_dec;
        if (!s_accept) begin
            cmd_cell.mode = MODE_NONE;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VAL_W-1:0] left_d;
        logic signed [VAL_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        alr_cell u_cell (
            .aclk       (aclk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd_cell),
            .rd         (rd_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // group merge of cell taps
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SZ; k++) begin
                if (g * GRP_SZ + k < CAPACITY) begin
                    grp_next[g] = grp_next[g] | cell_tap[g * GRP_SZ + k];
                end
            end
        end
    end

    always_comb begin
        rdval_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            rdval_next = rdval_next | grp_reg[g];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_TAP;
                end
            end
            S_TAP: begin
                state_next = S_GRP;
            end
            S_GRP: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                used_reg <= used_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_reg[g] <= grp_next[g];
        end
        if (s_accept) begin
            rd_reg   <= rd_dec;
            stat_reg <= stat_dec;
            cnt_reg  <= used_dec;
        end
        if (state_reg == S_SUM) begin
            rdval_reg <= rdval_next;
        end
    end

endmodule

FILE: sv/alr_checker.sv
// port-level checker for the shifting array list, bound to the top level
// depends on alr_pkg and shifting_array_list_defines.svh
`include "shifting_array_list_defines.svh"

module alr_checker
    import alr_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // count never beyond capacity
    `ALR_ASSERT_IMPL(a_count_range, m_tvalid, m_tdata[38:32] <= 7'(CAPACITY))
    // failed request reads zero
    `ALR_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tdata[40:39] != ST_OK), m_tdata[31:0] == '0)
    // no result in the cycle after a request is taken
    `ALR_ASSERT_NEXT(a_no_early, s_tvalid && s_tready, !m_tvalid)
    // stalled result holds
    `ALR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind shifting_array_list alr_checker u_alr_checker (.*);
